// ===== design/tes_pkg.sv =====
// shared types, widths and constants of the triangle element stiffness pipeline
`default_nettype none
package tes_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int FRAC_SH = 15;
   localparam int NUM_W   = SUM_W + FRAC_SH;
   localparam int DEN_W   = PROD_W;
   localparam int QUO_W   = 32;
   localparam int SH_W    = DEN_W + QUO_W - 1;
   localparam int NP      = 6;
   localparam int NL      = NP + 1;
   localparam int MASS_LANE = NP;
   localparam int REQ_W   = 6 * COORD_W;
   localparam int RSP_W   = NL * QUO_W;

   // mass share is (twice the area >> 17) / 3, the divide by three by reciprocal multiply
   localparam int MASS_SH  = 17;
   localparam int MASS_W   = 33;
   localparam int MASS_P_W = 2 * MASS_W;
   localparam int MASS_RSH = MASS_W + 1;
   localparam int MASS_M_W = DEN_W - MASS_SH;
   // ceil(2^34 / 3), exact for any 33-bit dividend
   localparam logic [MASS_W-1:0]   MASS_RECIP = 33'h1_5555_5556;
   // shifted area at which area/3 no longer fits in 31 bits
   localparam logic [MASS_M_W-1:0] MASS_LIMIT = MASS_M_W'(33'h1_8000_0000);

   localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

   // row and column of each distinct matrix entry, k11 k12 k13 k22 k23 k33
   localparam logic [1:0] PAIR_I [NP] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PAIR_J [NP] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NEG_AREA  = 2'd1,
      STATUS_ZERO_AREA = 2'd2
   } status_type;

   // input word, ax in the lowest bits
   typedef struct packed {
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] ax;
   } tri_type;

   // word moving through the divider stages
   typedef struct packed {
      logic [DEN_W-1:0]           den;
      logic [NP-1:0][NUM_W-1:0]   rem;
      logic [NP-1:0][QUO_W-1:0]   quo;
      logic [NP-1:0]              neg;
      status_type                 status;
   } div_word_type;

   typedef struct packed {
      logic [NL-1:0][QUO_W-1:0] val;
      status_type               status;
   } result_type;

endpackage
`default_nettype wire

// ===== design/triangle_element_stiffness.sv =====
// top level of the linear triangle conduction and lumped mass element pipeline
// One triangle per word goes in (three vertices, signed Q16.16) and one word comes out
// with the six distinct entries of the symmetric 3x3 conduction matrix, the lumped mass
// share area/3 (all Q16.16, truncated toward zero, saturated to 32 bits) and a status
// code: ok, negative area (clockwise) or zero area; on either bad status all entries are
// zero. The block takes one triangle every cycle when nothing stalls; each triangle passes
// through three front stages (differences, fourteen 33x33 multipliers, sums), 32
// restoring division stages that each settle one quotient bit of the six matrix lanes
// with one wide compare and subtract per lane, and the output register, which also forms
// area/3 from the carried area by a shift and a multiply with the reciprocal of three.
// Every stage holds its own valid bit, so bubbles close up and input keeps flowing
// while a finished result waits on rsp_tready.
`default_nettype none
module triangle_element_stiffness
   import tes_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [REQ_W-1:0]  req_tdata,   // ax, ay, bx, by, cx, cy
   // result channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata,   // k11, k12, k13, k22, k23, k33, mass_share
   output logic [1:0]             rsp_tuser    // status
);

   localparam int NSTAGE = QUO_W;

   // divider chain handshake, index 0 is the front output
   logic         dv [NSTAGE+1];
   logic         dr [NSTAGE+1];
   div_word_type dw [NSTAGE+1];

   result_type   result;

   // differences, products and area
   tes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_tri    (tri_type'(req_tdata)),
      .out_valid (dv[0]),
      .out_ready (dr[0]),
      .out_word  (dw[0])
   );

   // one quotient bit per stage, from the top bit down
   for (genvar g = 0; g < NSTAGE; g++) begin : g_div
      tes_div_stage #(
         .BIT (NSTAGE - 1 - g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv[g]),
         .in_ready  (dr[g]),
         .in_word   (dw[g]),
         .out_valid (dv[g+1]),
         .out_ready (dr[g+1]),
         .out_word  (dw[g+1])
      );
   end

   // saturate, apply sign and status, hold for the consumer
   tes_out u_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dv[NSTAGE]),
      .in_ready   (dr[NSTAGE]),
      .in_word    (dw[NSTAGE]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = result.val;
   assign rsp_tuser = result.status;

   // a bad triangle never carries nonzero entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> rsp_tdata == '0)
      else $error("nonzero entries on a flagged triangle");

   // area is positive on good triangles, so the mass share is never negative
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_OK) |-> !rsp_tdata[RSP_W-1])
      else $error("negative mass share on a good triangle");

   // a stalled divider stage keeps its word
   assert property (@(posedge clock) disable iff (reset)
      dv[1] && !dr[1] |=> dv[1] && $stable(dw[1]))
      else $error("divider stage lost its word under stall");

endmodule
`default_nettype wire

// ===== design/tes_front.sv =====
// front stages: vertex differences, products, area, numerators and magnitudes
`default_nettype none
module tes_front
   import tes_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire tri_type      in_tri,
   output logic              out_valid,
   input  wire logic         out_ready,
   output div_word_type      out_word
);

   logic valid1_ff, valid2_ff, valid3_ff;
   logic ready1, ready2, ready3;

   logic signed [DIFF_W-1:0] db_in [3];
   logic signed [DIFF_W-1:0] dc_in [3];
   logic signed [DIFF_W-1:0] db_ff [3];
   logic signed [DIFF_W-1:0] dc_ff [3];

   logic signed [PROD_W-1:0] bb_in [NP];
   logic signed [PROD_W-1:0] cc_in [NP];
   logic signed [PROD_W-1:0] bb_ff [NP];
   logic signed [PROD_W-1:0] cc_ff [NP];
   logic signed [PROD_W-1:0] pa_in, pb_in, pa_ff, pb_ff;

   logic signed [SUM_W-1:0] num_s [NP];
   logic [SUM_W-1:0]        mag_s [NP];
   logic signed [SUM_W-1:0] area2_s;
   div_word_type            word_in, word_ff;

   assign ready3   = !valid3_ff || out_ready;
   assign ready2   = !valid2_ff || ready3;
   assign ready1   = !valid1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: gradients scaled by twice the area
   always_comb begin
      db_in[0] = DIFF_W'(in_tri.by) - DIFF_W'(in_tri.cy);
      db_in[1] = DIFF_W'(in_tri.cy) - DIFF_W'(in_tri.ay);
      db_in[2] = DIFF_W'(in_tri.ay) - DIFF_W'(in_tri.by);
      dc_in[0] = DIFF_W'(in_tri.cx) - DIFF_W'(in_tri.bx);
      dc_in[1] = DIFF_W'(in_tri.ax) - DIFF_W'(in_tri.cx);
      dc_in[2] = DIFF_W'(in_tri.bx) - DIFF_W'(in_tri.ax);
   end

   // stage 2: all products, twice the area is dc2*db1 - dc1*db2
   always_comb begin
      for (int k = 0; k < NP; k++) begin
         bb_in[k] = PROD_W'(db_ff[PAIR_I[k]]) * PROD_W'(db_ff[PAIR_J[k]]);
         cc_in[k] = PROD_W'(dc_ff[PAIR_I[k]]) * PROD_W'(dc_ff[PAIR_J[k]]);
      end
      pa_in = PROD_W'(dc_ff[2]) * PROD_W'(db_ff[1]);
      pb_in = PROD_W'(dc_ff[1]) * PROD_W'(db_ff[2]);
   end

   // stage 3: sums, sign split and scaling into the divider word
   always_comb begin
      area2_s = SUM_W'(pa_ff) - SUM_W'(pb_ff);
      word_in = '0;
      for (int k = 0; k < NP; k++) begin
         num_s[k] = SUM_W'(bb_ff[k]) + SUM_W'(cc_ff[k]);
         mag_s[k] = num_s[k][SUM_W-1] ? SUM_W'(-num_s[k]) : SUM_W'(num_s[k]);
         word_in.rem[k] = NUM_W'(mag_s[k]) << FRAC_SH;
         word_in.neg[k] = num_s[k][SUM_W-1];
      end
      word_in.den = area2_s[DEN_W-1:0];
      if (area2_s[SUM_W-1]) begin
         word_in.status = STATUS_NEG_AREA;
      end else if (area2_s == '0) begin
         word_in.status = STATUS_ZERO_AREA;
      end else begin
         word_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (ready1) valid1_ff <= in_valid;
         if (ready2) valid2_ff <= valid1_ff;
         if (ready3) valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         db_ff <= db_in;
         dc_ff <= dc_in;
      end
      if (ready2) begin
         bb_ff <= bb_in;
         cc_ff <= cc_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ready3) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

// ===== design/tes_div_stage.sv =====
// one restoring division step: one quotient bit for every lane
`default_nettype none
module tes_div_stage
   import tes_pkg::*;
#(
   parameter int BIT = 0
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire div_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_ready,
   output div_word_type      out_word
);

   logic              valid_ff;
   div_word_type      word_in, word_ff;
   logic [SH_W-1:0]   rem_w   [NP];
   logic [SH_W-1:0]   shifted;
   logic [NP-1:0]     ge;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      word_in = in_word;
      shifted = SH_W'(in_word.den) << BIT;
      for (int l = 0; l < NP; l++) begin
         rem_w[l]   = SH_W'(in_word.rem[l]);
         ge[l]      = rem_w[l] >= shifted;
         word_in.rem[l] = ge[l] ? NUM_W'(rem_w[l] - shifted) : in_word.rem[l];
         word_in.quo[l] = in_word.quo[l] | (QUO_W'(ge[l]) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule
`default_nettype wire

// ===== design/tes_out.sv =====
// output register: sign, saturation and status masking of the quotients, mass share
`default_nettype none
module tes_out
   import tes_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire div_word_type in_word,
   output logic              out_valid,
   input  wire logic         out_ready,
   output result_type        out_result
);

   logic                valid_ff;
   result_type          result_in, result_ff;
   logic [MASS_M_W-1:0] mass_m;
   logic [MASS_P_W-1:0] mass_p;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      result_in.status = in_word.status;
      for (int l = 0; l < NP; l++) begin
         if (in_word.status != STATUS_OK) begin
            result_in.val[l] = '0;
         end else if (in_word.quo[l][QUO_W-1]) begin
            result_in.val[l] = in_word.neg[l] ? SAT_NEG : SAT_POS;
         end else if (in_word.neg[l]) begin
            result_in.val[l] = QUO_W'(0) - in_word.quo[l];
         end else begin
            result_in.val[l] = in_word.quo[l];
         end
      end
      // area/3 in Q16.16 is floor(floor(2A / 2^17) / 3)
      mass_m = in_word.den[DEN_W-1:MASS_SH];
      mass_p = MASS_P_W'(MASS_W'(mass_m)) * MASS_P_W'(MASS_RECIP);
      if (in_word.status != STATUS_OK) begin
         result_in.val[MASS_LANE] = '0;
      end else if (mass_m >= MASS_LIMIT) begin
         result_in.val[MASS_LANE] = SAT_POS;
      end else begin
         result_in.val[MASS_LANE] = mass_p[MASS_P_W-1:MASS_RSH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking stream testbench for the triangle element stiffness pipeline
`default_nettype none
module testbench
   import tes_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_TRIANGLES = 1100;
   localparam int RESET_CYCLES     = 8;
   // room for the pipeline to drain when nothing stalls, with some slack at the end
   localparam int DRAIN_CYCLES     = 48;
   // longest quiet stretch is the long receiver hold-off plus the pipeline depth
   localparam int LONG_HOLD        = 300;
   localparam int WATCHDOG_LIMIT   = 4000;
   // no idling on either side once this few triangles are left to send
   localparam int QUIET_TAIL       = 100;
   localparam int MAX_REPORTS      = 40;

   localparam logic [31:0] ONE     = 32'h0001_0000;
   localparam logic [31:0] TWO     = 32'h0002_0000;
   localparam logic [31:0] THREE   = 32'h0003_0000;
   localparam logic [31:0] FIVE    = 32'h0005_0000;
   localparam logic [31:0] TEN     = 32'h000A_0000;
   localparam logic [31:0] NEG_TEN = 32'hFFF6_0000;
   localparam logic [31:0] SQRT3   = 32'h0001_BBA8;   // approximately sqrt(3) in Q16.16
   localparam logic [31:0] CMAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] CMIN    = 32'h8000_0000;

   // divisor that turns twice the area (Q32.32) into area/3 in Q16.16
   localparam logic [127:0] MASS_DIVISOR = 128'd393216;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_tvalid = 1'b0;
   logic             req_tready;
   tri_type          req_tdata  = '0;     // ax, ay, bx, by, cx, cy
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;           // k11, k12, k13, k22, k23, k33, mass_share
   logic [1:0]       rsp_tuser;           // status

   // triangles waiting to be offered, and predicted words waiting on the result side
   tri_type    pending_triangles[$];
   result_type predicted_elements[$];

   int  error_count     = 0;
   int  accepted_count  = 0;
   int  results_seen    = 0;
   int  send_gap        = 0;
   int  recv_hold       = 0;
   int  send_idle_pct   = 20;
   int  recv_idle_pct   = 20;
   int  stall_cycles    = 0;
   logic long_hold_done = 1'b0;
   logic quiet_tail     = 1'b0;

   string lane_name [NL] = '{"k11", "k12", "k13", "k22", "k23", "k33", "mass_share"};

   triangle_element_stiffness DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // truncated quotient of an exact numerator by a positive denominator, saturated to 32 bits
   function automatic logic [31:0] clamp_quotient(logic signed [127:0] num,
                                                  logic [127:0] den);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] quo;
      neg = (num < 0);
      mag = neg ? -num : num;
      quo = mag / den;
      if (neg) begin
         if (quo > 128'h8000_0000) return SAT_NEG;
         return 32'h0 - quo[31:0];
      end
      if (quo > 128'h7FFF_FFFF) return SAT_POS;
      return quo[31:0];
   endfunction

   // conduction entries, mass share and status of one triangle, all exact until the divide
   function automatic result_type element_matrices(tri_type t);
      logic signed [127:0] x1, y1, x2, y2, x3, y3;
      logic signed [127:0] twice_area;
      logic signed [127:0] num;
      logic signed [127:0] grad_b [3];
      logic signed [127:0] grad_c [3];
      result_type r;
      int lane;
      x1 = {{96{t.ax[31]}}, t.ax};
      y1 = {{96{t.ay[31]}}, t.ay};
      x2 = {{96{t.bx[31]}}, t.bx};
      y2 = {{96{t.by[31]}}, t.by};
      x3 = {{96{t.cx[31]}}, t.cx};
      y3 = {{96{t.cy[31]}}, t.cy};
      twice_area = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
      r = '0;
      if (twice_area < 0) begin
         r.status = STATUS_NEG_AREA;
         return r;
      end
      if (twice_area == 0) begin
         r.status = STATUS_ZERO_AREA;
         return r;
      end
      grad_b[0] = y2 - y3;
      grad_b[1] = y3 - y1;
      grad_b[2] = y1 - y2;
      grad_c[0] = x3 - x2;
      grad_c[1] = x1 - x3;
      grad_c[2] = x2 - x1;
      lane = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = i; j < 3; j++) begin
            num = (grad_b[i] * grad_b[j] + grad_c[i] * grad_c[j]) <<< 15;
            r.val[lane] = clamp_quotient(num, twice_area);
            lane++;
         end
      end
      r.val[MASS_LANE] = clamp_quotient(twice_area, MASS_DIVISOR);
      r.status = STATUS_OK;
      return r;
   endfunction

   function automatic void queue_triangle(logic [31:0] ax, logic [31:0] ay,
                                          logic [31:0] bx, logic [31:0] by,
                                          logic [31:0] cx, logic [31:0] cy);
      tri_type t;
      t.ax = ax;
      t.ay = ay;
      t.bx = bx;
      t.by = by;
      t.cx = cx;
      t.cy = cy;
      pending_triangles.push_back(t);
   endfunction

   // random signed value spanning about +-2^(bits-1)
   function automatic logic [31:0] spread(int bits);
      return 32'($signed($urandom) >>> (32 - bits));
   endfunction

   // sender: holds a word until it is taken, with short random gaps between words
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_elements.push_back(element_matrices(req_tdata));
            accepted_count <= accepted_count + 1;
            // switch the idling rate now and then, zero gives stretches without gaps
            if (accepted_count % 128 == 127) begin
               case ($urandom_range(0, 2))
                  0: send_idle_pct <= 0;
                  1: send_idle_pct <= 15;
                  default: send_idle_pct <= 45;
               endcase
            end
         end
         quiet_tail <= (pending_triangles.size() < QUIET_TAIL);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 && !quiet_tail) begin
               req_tvalid <= 1'b0;
               send_gap   <= send_gap - 1;
            end else if (pending_triangles.size() != 0) begin
               req_tdata  <= pending_triangles.pop_front();
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 99) < send_idle_pct) send_gap <= $urandom_range(1, 3);
               else send_gap <= 0;
            end else begin
               req_tvalid <= 1'b0;
               send_gap   <= 0;
            end
         end
      end
   end

   // receiver: short random stalls, plus one long hold-off so the pipeline backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready     <= 1'b0;
         recv_hold      <= 0;
         long_hold_done <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
         rsp_tready     <= 1'b0;
         recv_hold      <= LONG_HOLD;
         long_hold_done <= 1'b1;
      end else if (recv_hold > 0) begin
         rsp_tready <= 1'b0;
         recv_hold  <= recv_hold - 1;
      end else if (!quiet_tail && $urandom_range(0, 99) < recv_idle_pct) begin
         rsp_tready <= 1'b0;
         recv_hold  <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: every taken result word against the oldest prediction, field by field
   always @(posedge clock) begin
      result_type want;
      logic [NL-1:0] wrong_lanes;
      logic status_wrong;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (results_seen % 128 == 127) begin
            case ($urandom_range(0, 2))
               0: recv_idle_pct <= 0;
               1: recv_idle_pct <= 15;
               default: recv_idle_pct <= 45;
            endcase
         end
         if (predicted_elements.size() == 0) begin
            error_count <= error_count + 1;
            if (error_count < MAX_REPORTS)
               $display("%t unexpected result word: expected none, actual status %0d data %h",
                        $time, rsp_tuser, rsp_tdata);
         end else begin
            want = predicted_elements.pop_front();
            for (int lane = 0; lane < NL; lane++)
               wrong_lanes[lane] = (rsp_tdata[lane*QUO_W +: QUO_W] != want.val[lane]);
            status_wrong = (rsp_tuser != want.status);
            if (status_wrong || wrong_lanes != '0) begin
               error_count <= error_count + 1;
               if (error_count < MAX_REPORTS)
                  $display("%t result %0d mismatch (lanes %b, status %0b): %s %0d %s %h, %s %0d %s %h",
                           $time, results_seen, wrong_lanes, status_wrong,
                           "expected status", want.status, "data", want.val,
                           "actual status", rsp_tuser, "data", rsp_tdata);
            end
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      tri_type t;
      result_type probe;
      logic [31:0] bx0, by0, dx, dy;
      int kind;
      int bits;
      int k;

      // directed: unit and raw-unit triangles, both windings
      queue_triangle(0, 0, ONE, 0, 0, ONE);
      queue_triangle(0, 0, 0, ONE, ONE, 0);
      queue_triangle(0, 0, 1, 0, 0, 1);
      queue_triangle(0, 0, 1, 1, 1, 2);           // smallest positive area
      queue_triangle(0, 0, 1, 2, 1, 1);           // smallest negative area
      queue_triangle(0, 0, TWO, 0, ONE, SQRT3);
      queue_triangle(NEG_TEN, NEG_TEN, TEN, NEG_TEN, NEG_TEN, TEN);
      // degenerate: collinear, coincident vertices, all equal at the extremes
      queue_triangle(0, 0, ONE, ONE, TWO, TWO);
      queue_triangle(0, 0, 0, 0, 0, 0);
      queue_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
      queue_triangle(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
      queue_triangle(CMIN, CMIN, 0, 0, CMAX, CMAX);
      queue_triangle(ONE, ONE, ONE, ONE, THREE, FIVE);
      // extreme coordinates, both windings; the huge positive areas saturate the mass share
      queue_triangle(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
      queue_triangle(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN);
      queue_triangle(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
      queue_triangle(CMAX, 0, CMIN, 0, 0, CMAX);
      // sliver triangles push entries into positive and negative saturation
      queue_triangle(0, 0, CMAX, 0, 0, 1);
      queue_triangle(CMIN, 0, CMAX, 0, 0, 1);
      queue_triangle(0, 0, 1, 0, 0, CMAX);
      queue_triangle(CMIN, CMAX, CMAX, CMAX, 0, CMIN);

      for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            // full range noise, every bit of every field
            queue_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else if (kind < 20) begin
            // collinear or coincident, kept small enough that nothing wraps
            bits = $urandom_range(1, 20);
            k    = $urandom_range(0, 6) - 3;
            bx0  = spread($urandom_range(1, 28));
            by0  = spread($urandom_range(1, 28));
            dx   = spread(bits);
            dy   = spread(bits);
            if ($urandom_range(0, 3) == 0) queue_triangle(bx0, by0, bx0 + dx, by0 + dy, bx0, by0);
            else queue_triangle(bx0, by0, bx0 + dx, by0 + dy, bx0 + dx * k, by0 + dy * k);
         end else begin
            // mesh-like element: a base point and offsets of a random scale
            bits = $urandom_range(2, 26);
            bx0  = spread($urandom_range(1, 30));
            by0  = spread($urandom_range(1, 30));
            t.ax = bx0 + spread(bits);
            t.ay = by0 + spread(bits);
            t.bx = bx0 + spread(bits);
            t.by = by0 + spread(bits);
            t.cx = bx0 + spread(bits);
            t.cy = by0 + spread(bits);
            // mostly counterclockwise, a few clockwise ones left in
            probe = element_matrices(t);
            if (probe.status == STATUS_NEG_AREA && $urandom_range(0, 9) != 0) begin
               dx   = t.bx;
               dy   = t.by;
               t.bx = t.cx;
               t.by = t.cy;
               t.cx = dx;
               t.cy = dy;
            end
            pending_triangles.push_back(t);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_triangles.size() != 0 || req_tvalid || predicted_elements.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
